>>> rtl/core/ips_patch_stream_parser_top_assert.svh
// Assertion macros used by the patch stream parser command queue.
`ifndef IPS_PATCH_STREAM_PARSER_TOP_ASSERT_SVH
`define IPS_PATCH_STREAM_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IPSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ipsp_pkg.sv
// Package with types, codes and constants of the patch stream parser.
`default_nettype none

package ipsp_pkg;

  // Result kinds.
  localparam logic [2:0] KIND_WRITE     = 3'd0;
  localparam logic [2:0] KIND_FILL      = 3'd1;
  localparam logic [2:0] KIND_DONE      = 3'd2;
  localparam logic [2:0] KIND_BAD_HDR   = 3'd3;
  localparam logic [2:0] KIND_TRUNCATED = 3'd4;

  // Offset value that marks the end of the patch.
  localparam logic [23:0] EOF_MARK = 24'h454F46;

  // Command queue between front and back.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] patch_byte;
    logic       last;
  } ipsp_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [24:0] address;
    logic [15:0] length;
    logic [7:0]  value;
    logic [24:0] extent;
    logic        stream_end;
  } ipsp_out_t;

  // Command from the parser front to the extent tracker.
  typedef struct packed {
    logic        load;        // start of stream: extent takes the source size
    logic        grow;        // record end may push the extent out
    logic [24:0] grow_end;
    logic        emit;        // a result goes out
    logic [2:0]  kind;
    logic [24:0] address;
    logic [15:0] length;
    logic [7:0]  value;
    logic        stream_end;
  } ipsp_cmd_t;

  // Expected header byte at a given position of "PATCH".
  function automatic logic [7:0] ipsp_sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h50;
      3'd1:    r = 8'h41;
      3'd2:    r = 8'h54;
      3'd3:    r = 8'h43;
      3'd4:    r = 8'h48;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ipsp_front.sv
// Parser front: walks the patch byte stream and turns bytes into commands.
`default_nettype none

module ipsp_front
  import ipsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire ipsp_in_t   in_req,
  input  wire logic       q_full,
  output logic            in_stall,
  output logic            cmd_push,
  output ipsp_cmd_t       cmd
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_OFFSET = 3'd1;
  localparam logic [2:0] PH_SIZE   = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_RUNLEN = 3'd4;
  localparam logic [2:0] PH_RUNVAL = 3'd5;
  localparam logic [2:0] PH_STOP   = 3'd6;

  logic [2:0]  phase_r,  phase_nxt;
  logic [2:0]  fcnt_r,   fcnt_nxt;
  logic [23:0] offset_r, offset_nxt;
  logic [15:0] size_r,   size_nxt;
  logic [15:0] left_r,   left_nxt;
  logic [24:0] waddr_r,  waddr_nxt;
  logic        failed_r, failed_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        lst;
  logic        hdr_fail;
  logic [23:0] off_asm;
  logic [15:0] size_lo;
  ipsp_cmd_t   c;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_req.patch_byte;
  assign lst      = in_req.last;

  // Field assembly helpers.
  assign hdr_fail = ((fcnt_r == 3'd0) ? 1'b0 : failed_r) | (b != ipsp_sig_byte(fcnt_r));
  assign off_asm  = (fcnt_r == 3'd0) ? {16'h0000, b} : {offset_r[15:0], b};
  assign size_lo  = {size_r[15:8], b};

  // Per-byte parse step.
  always_comb begin
    phase_nxt  = phase_r;
    fcnt_nxt   = fcnt_r;
    offset_nxt = offset_r;
    size_nxt   = size_r;
    left_nxt   = left_r;
    waddr_nxt  = waddr_r;
    failed_nxt = failed_r;
    c          = '0;

    unique case (phase_r) inside
      PH_HEADER: begin
        c.load     = (fcnt_r == 3'd0);
        failed_nxt = hdr_fail;
        if (fcnt_r >= 3'd4) begin
          fcnt_nxt = 3'd0;
          if (hdr_fail) begin
            c.emit    = 1'b1;
            c.kind    = KIND_BAD_HDR;
            phase_nxt = PH_STOP;
          end else begin
            phase_nxt = PH_OFFSET;
            if (lst) begin
              c.emit = 1'b1;
              c.kind = KIND_DONE;
            end
          end
        end else begin
          fcnt_nxt = fcnt_r + 3'd1;
          if (lst) begin
            c.emit = 1'b1;
            c.kind = KIND_BAD_HDR;
          end
        end
      end
      PH_OFFSET: begin
        offset_nxt = off_asm;
        if (fcnt_r >= 3'd2) begin
          fcnt_nxt = 3'd0;
          if (off_asm == EOF_MARK) begin
            c.emit    = 1'b1;
            c.kind    = KIND_DONE;
            phase_nxt = PH_STOP;
          end else begin
            phase_nxt = PH_SIZE;
            if (lst) begin
              c.emit = 1'b1;
              c.kind = KIND_TRUNCATED;
            end
          end
        end else begin
          fcnt_nxt = fcnt_r + 3'd1;
          if (lst) begin
            c.emit = 1'b1;
            c.kind = KIND_TRUNCATED;
          end
        end
      end
      PH_SIZE, PH_RUNLEN: begin
        if (fcnt_r == 3'd0) begin
          size_nxt = {b, 8'h00};
          fcnt_nxt = 3'd1;
        end else begin
          size_nxt = size_lo;
          fcnt_nxt = 3'd0;
          if (phase_r == PH_RUNLEN) begin
            phase_nxt = PH_RUNVAL;
          end else if (size_lo != 16'h0000) begin
            c.grow     = 1'b1;
            c.grow_end = {1'b0, offset_r} + {9'h000, size_lo};
            left_nxt   = size_lo;
            waddr_nxt  = {1'b0, offset_r};
            phase_nxt  = PH_DATA;
          end else begin
            phase_nxt = PH_RUNLEN;
          end
        end
        if (lst) begin
          c.emit = 1'b1;
          c.kind = KIND_TRUNCATED;
        end
      end
      PH_DATA: begin
        c.emit = 1'b1;
        if (lst && (left_r > 16'd1)) begin
          c.kind = KIND_TRUNCATED;
        end else begin
          c.kind    = KIND_WRITE;
          c.address = waddr_r;
          c.length  = 16'd1;
          c.value   = b;
          waddr_nxt = waddr_r + 25'd1;
          if (left_r <= 16'd1) begin
            left_nxt  = 16'd0;
            phase_nxt = PH_OFFSET;
            fcnt_nxt  = 3'd0;
          end else begin
            left_nxt = left_r - 16'd1;
          end
        end
      end
      PH_RUNVAL: begin
        c.grow     = 1'b1;
        c.grow_end = {1'b0, offset_r} + {9'h000, size_r};
        c.emit     = 1'b1;
        c.kind     = KIND_FILL;
        c.address  = {1'b0, offset_r};
        c.length   = size_r;
        c.value    = b;
        phase_nxt  = PH_OFFSET;
        fcnt_nxt   = 3'd0;
      end
      PH_STOP: begin
        c = '0;
      end
      default: begin
        phase_nxt = PH_HEADER;
        fcnt_nxt  = 3'd0;
      end
    endcase

    // The final byte of a stream rearms the header check.
    if (lst) begin
      phase_nxt = PH_HEADER;
      fcnt_nxt  = 3'd0;
    end
    c.stream_end = lst & c.emit;
  end

  assign cmd      = c;
  assign cmd_push = accept && (c.emit || c.grow || c.load);

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      fcnt_r   <= 3'd0;
      offset_r <= 24'd0;
      size_r   <= 16'd0;
      left_r   <= 16'd0;
      waddr_r  <= 25'd0;
      failed_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      fcnt_r   <= fcnt_nxt;
      offset_r <= offset_nxt;
      size_r   <= size_nxt;
      left_r   <= left_nxt;
      waddr_r  <= waddr_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ipsp_fifo.sv
// Short command queue that decouples the parser front from the back.
`default_nettype none

`include "ips_patch_stream_parser_top_assert.svh"

module ipsp_fifo
  import ipsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire ipsp_cmd_t  push_cmd,
  input  wire logic       pop,
  output logic            full,
  output logic            head_valid,
  output ipsp_cmd_t       head_cmd
);

  ipsp_cmd_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]     count_r,  count_nxt;
  logic                   do_push;
  logic                   do_pop;

  assign full       = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + FIFO_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + FIFO_AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + FIFO_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `IPSP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= FIFO_CW'(FIFO_DEPTH), "queue count exceeds depth")
  `IPSP_ASSERT_NEXT(a_pop_only, clk, rst_n, do_pop && !do_push, count_r == $past(count_r) - FIFO_CW'(1), "pop did not drain one entry")
  `IPSP_ASSERT_NOW(a_ptr_gap, clk, rst_n, count_r == '0, wr_ptr_r == rd_ptr_r, "empty queue with pointers apart")

endmodule

`default_nettype wire

>>> rtl/core/ipsp_back.sv
// Back end: tracks the image extent and holds the result register.
`default_nettype none

module ipsp_back
  import ipsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [23:0] cfg_data,
  input  wire logic        head_valid,
  input  wire ipsp_cmd_t   head_cmd,
  output logic             pop,
  input  wire logic        out_stall,
  output logic             out_valid,
  output ipsp_out_t        out_rsp
);

  logic [23:0] init_size_r;
  logic [24:0] extent_r;
  logic [24:0] ext_base;
  logic [24:0] ext_new;
  logic        out_valid_r, out_valid_nxt;
  ipsp_out_t   out_r;

  // A command is taken when the result register is free or being drained.
  assign pop = head_valid && (!out_valid_r || !out_stall);

  // Extent after this command: start of stream loads the source size, then grow.
  assign ext_base = head_cmd.load ? {1'b0, init_size_r} : extent_r;
  assign ext_new  = (head_cmd.grow && (head_cmd.grow_end > ext_base)) ?
                    head_cmd.grow_end : ext_base;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && head_cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_size_r <= 24'd0;
      extent_r    <= 25'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        init_size_r <= cfg_data;
      end
      if (pop) begin
        extent_r <= ext_new;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (pop && head_cmd.emit) begin
      out_r.kind       <= head_cmd.kind;
      out_r.address    <= head_cmd.address;
      out_r.length     <= head_cmd.length;
      out_r.value      <= head_cmd.value;
      out_r.extent     <= ext_new;
      out_r.stream_end <= head_cmd.stream_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

endmodule

`default_nettype wire

>>> rtl/core/ips_patch_stream_parser_top.sv
// Top level of the patch stream parser.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall   | ipsp_in_t (patch_byte, last)
//   out_    | output    | out_valid/out_stall | ipsp_out_t (kind .. stream_end)
//   cfg_    | input     | cfg_valid/cfg_ready | initial_size, 24 bits
//
// One patch byte is taken per cycle while the command queue is not full;
// the front parses it combinationally. A result is registered first in the
// four-entry command queue, then in the back end's result register.
// Reset is synchronous and active low; cfg_ready is always high.
// in_stall rises only when the command queue is full, so a stalled result
// channel stops input once four commands wait in the queue behind the held result.
`default_nettype none

module ips_patch_stream_parser_top
  import ipsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire ipsp_in_t    in_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ipsp_out_t        out_rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_data
);

  logic       q_full;
  logic       cmd_push;
  ipsp_cmd_t  cmd;
  logic       q_pop;
  logic       head_valid;
  ipsp_cmd_t  head_cmd;

  assign cfg_ready = 1'b1;

  ipsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_req   (in_req),
    .q_full   (q_full),
    .in_stall (in_stall),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  ipsp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  ipsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_rsp    (out_rsp)
  );

endmodule

`default_nettype wire
